// ===== hdl/gif_frame_compositor_macros.svh =====
// Assertion macros shared by the compositor RTL.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef GIF_FRAME_COMPOSITOR_MACROS_SVH
`define GIF_FRAME_COMPOSITOR_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define GFC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Expression must never be true outside reset.
`define GFC_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== hdl/gfc_pkg.sv =====
// Package of the frame compositor: operation, disposal, register and state codes,
// the draw request struct and the screen size helper. No dependencies.
package gfc_pkg;

  // Default sizes handed down as top level parameters
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_PALETTE_SIZE = 256;

  // Bits of a cell count: up to 511 x 511 cells from the 9-bit size registers
  localparam int CELL_W = 18;
  localparam int DIM_W  = 9;
  localparam int POS_W  = 16;
  localparam int WORD_W = 32;
  localparam int RGB_W  = 24;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    OP_LOAD_PALETTE = 3'd0,
    OP_CLEAR        = 3'd1,
    OP_BEGIN_FRAME  = 3'd2,
    OP_PIXEL        = 3'd3,
    OP_READ         = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    DISP_NONE       = 2'd0,
    DISP_KEEP       = 2'd1,
    DISP_BACKGROUND = 2'd2,
    DISP_PREVIOUS   = 2'd3
  } disp_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH      = 2'd0,
    REG_HEIGHT     = 2'd1,
    REG_BACKGROUND = 2'd2
  } reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WRITE
  } state_e;

  // Draw request of the current raster pixel
  typedef struct packed {
    logic              draw;
    logic [CELL_W-1:0] offset;
  } draw_t;

  // Effective screen dimension: zero reads as one, large values saturate
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] v, int unsigned lim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > lim) begin
      r = DIM_W'(lim);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== hdl/gfc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module gfc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data follows in the next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/gfc_cursor.sv =====
// Frame state and raster cursor: holds the frame rectangle and transparency,
// walks the cursor and forms the canvas offset of each pixel. Uses gfc_pkg.
module gfc_cursor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          begin_i,
  input  logic                          step_i,
  input  logic [gfc_pkg::POS_W-1:0]     rect_left_i,
  input  logic [gfc_pkg::POS_W-1:0]     rect_top_i,
  input  logic [gfc_pkg::POS_W-1:0]     rect_right_i,
  input  logic [gfc_pkg::POS_W-1:0]     rect_bottom_i,
  input  logic                          transparency_on_i,
  input  logic [7:0]                    transparent_index_i,
  input  logic [7:0]                    raster_index_i,
  input  logic [gfc_pkg::DIM_W-1:0]     width_i,
  input  logic [gfc_pkg::DIM_W-1:0]     height_i,
  output gfc_pkg::draw_t                draw_o
);

  logic [gfc_pkg::POS_W-1:0] col_q, row_q;
  logic [gfc_pkg::POS_W-1:0] left_q, right_q, bottom_q;
  logic                      trans_on_q;
  logic [7:0]                trans_idx_q;
  logic                      active_q;

  logic [gfc_pkg::POS_W:0]    col_inc, row_inc;
  logic                       wrap, last_row;
  logic                       in_canvas, transparent;
  logic [gfc_pkg::CELL_W-1:0] row_base;

  // Cursor advance, one bit wider so the step past 65535 still compares
  assign col_inc  = {1'b0, col_q} + (gfc_pkg::POS_W+1)'(1);
  assign row_inc  = {1'b0, row_q} + (gfc_pkg::POS_W+1)'(1);
  assign wrap     = col_inc >= {1'b0, right_q};
  assign last_row = row_inc >= {1'b0, bottom_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
      right_q     <= '0;
      bottom_q    <= '0;
      trans_on_q  <= 1'b0;
      trans_idx_q <= '0;
      active_q    <= 1'b0;
    end else if (begin_i) begin
      col_q       <= rect_left_i;
      row_q       <= rect_top_i;
      left_q      <= rect_left_i;
      right_q     <= rect_right_i;
      bottom_q    <= rect_bottom_i;
      trans_on_q  <= transparency_on_i;
      trans_idx_q <= transparent_index_i;
      active_q    <= (rect_right_i > rect_left_i) && (rect_bottom_i > rect_top_i);
    end else if (step_i && active_q) begin
      if (wrap) begin
        col_q <= left_q;
        row_q <= row_inc[gfc_pkg::POS_W-1:0];
        if (last_row) begin
          active_q <= 1'b0;
        end
      end else begin
        col_q <= col_inc[gfc_pkg::POS_W-1:0];
      end
    end
  end

  // Pixel visibility and canvas offset row * width + column
  assign in_canvas   = (col_q < gfc_pkg::POS_W'(width_i)) &&
                       (row_q < gfc_pkg::POS_W'(height_i));
  assign transparent = trans_on_q && (raster_index_i == trans_idx_q);
  assign row_base    = gfc_pkg::CELL_W'(row_q[gfc_pkg::DIM_W-1:0]) *
                       gfc_pkg::CELL_W'(width_i);

  assign draw_o.draw   = active_q && in_canvas && !transparent;
  assign draw_o.offset = row_base + gfc_pkg::CELL_W'(col_q[gfc_pkg::DIM_W-1:0]);

endmodule

// ===== hdl/gif_frame_compositor.sv =====
// Frame compositor: one item at a time. A palette load, a read, or a pixel
// that is not drawn keeps the block idle; a drawn pixel reads the palette and
// canvas word, then writes back with the old alpha byte. A clear, and a frame
// begin with background disposal, sweep all width * height cells: the single
// canvas write port stores one word a cycle. busy is high in all cycles after
// the first. A read result shows on result_valid_o for one cycle, the cycle
// after the read is taken; the receiver cannot stall it.
`include "gif_frame_compositor_macros.svh"

module gif_frame_compositor #(
  parameter int MAX_WIDTH    = gfc_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = gfc_pkg::DEF_MAX_HEIGHT,
  parameter int PALETTE_SIZE = gfc_pkg::DEF_PALETTE_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we_i,
  input  logic [gfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gfc_pkg::WORD_W-1:0]        cfg_data_i,
  input  logic [2:0]                        operation_i,
  input  logic [7:0]                        palette_index_i,
  input  logic [gfc_pkg::RGB_W-1:0]         palette_color_i,
  input  logic [1:0]                        disposal_i,
  input  logic [gfc_pkg::POS_W-1:0]         rect_left_i,
  input  logic [gfc_pkg::POS_W-1:0]         rect_top_i,
  input  logic [gfc_pkg::POS_W-1:0]         rect_right_i,
  input  logic [gfc_pkg::POS_W-1:0]         rect_bottom_i,
  input  logic                              transparency_on_i,
  input  logic [7:0]                        transparent_index_i,
  input  logic [7:0]                        raster_index_i,
  input  logic [gfc_pkg::POS_W-1:0]         read_address_i,
  output logic                              result_valid_o,
  output logic [gfc_pkg::WORD_W-1:0]        pixel_word_o,
  output logic                              address_error_o
);

  localparam int CanvasDepth = MAX_WIDTH * MAX_HEIGHT;
  localparam int CanvasAw    = $clog2(CanvasDepth);
  localparam int PalAw       = $clog2(PALETTE_SIZE);

  // Configuration registers
  logic [gfc_pkg::DIM_W-1:0]  width_q, height_q;
  logic [gfc_pkg::WORD_W-1:0] bg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 9'd256;
      height_q <= 9'd256;
      bg_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gfc_pkg::REG_WIDTH:      width_q  <= cfg_data_i[gfc_pkg::DIM_W-1:0];
        gfc_pkg::REG_HEIGHT:     height_q <= cfg_data_i[gfc_pkg::DIM_W-1:0];
        gfc_pkg::REG_BACKGROUND: bg_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective screen size and cell count
  logic [gfc_pkg::DIM_W-1:0]  eff_w, eff_h;
  logic [gfc_pkg::CELL_W-1:0] n_cells, last_cell;

  assign eff_w     = gfc_pkg::eff_dim(width_q, MAX_WIDTH);
  assign eff_h     = gfc_pkg::eff_dim(height_q, MAX_HEIGHT);
  assign n_cells   = gfc_pkg::CELL_W'(eff_w) * gfc_pkg::CELL_W'(eff_h);
  assign last_cell = n_cells - gfc_pkg::CELL_W'(1);

  // Item decode
  logic accept, acc_load, acc_clear, acc_begin, acc_pixel, acc_read;
  logic read_in_range, pal_load_ok, pal_idx_ok;

  assign accept        = start && !busy;
  assign acc_load      = accept && (operation_i == gfc_pkg::OP_LOAD_PALETTE);
  assign acc_clear     = accept && (operation_i == gfc_pkg::OP_CLEAR);
  assign acc_begin     = accept && (operation_i == gfc_pkg::OP_BEGIN_FRAME);
  assign acc_pixel     = accept && (operation_i == gfc_pkg::OP_PIXEL);
  assign acc_read      = accept && (operation_i == gfc_pkg::OP_READ);
  assign read_in_range = gfc_pkg::CELL_W'(read_address_i) < n_cells;
  assign pal_load_ok   = 32'(palette_index_i) < PALETTE_SIZE;
  assign pal_idx_ok    = 32'(raster_index_i) < PALETTE_SIZE;

  // Cursor and frame state
  gfc_pkg::draw_t draw;

  gfc_cursor u_cursor (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .begin_i             (acc_begin),
    .step_i              (acc_pixel),
    .rect_left_i         (rect_left_i),
    .rect_top_i          (rect_top_i),
    .rect_right_i        (rect_right_i),
    .rect_bottom_i       (rect_bottom_i),
    .transparency_on_i   (transparency_on_i),
    .transparent_index_i (transparent_index_i),
    .raster_index_i      (raster_index_i),
    .width_i             (eff_w),
    .height_i            (eff_h),
    .draw_o              (draw)
  );

  // Control state machine
  gfc_pkg::state_e            state_q, state_d;
  logic [gfc_pkg::CELL_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [gfc_pkg::CELL_W-1:0] wr_off_q;
  logic                       color_ok_q;
  logic                       res_valid_q, res_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gfc_pkg::ST_IDLE;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
      res_err_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= acc_read;
      if (acc_read) begin
        res_err_q <= !read_in_range;
      end
    end
  end

  // Pixel write-back beat payload
  always_ff @(posedge clk_i) begin
    if (acc_pixel) begin
      wr_off_q   <= draw.offset;
      color_ok_q <= pal_idx_ok;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    busy      = 1'b1;
    unique case (state_q)
      gfc_pkg::ST_IDLE: begin
        busy      = 1'b0;
        clr_cnt_d = '0;
        if (acc_clear ||
            (acc_begin && (disposal_i == gfc_pkg::DISP_BACKGROUND))) begin
          state_d = gfc_pkg::ST_CLEAR;
        end else if (acc_pixel && draw.draw) begin
          state_d = gfc_pkg::ST_WRITE;
        end
      end
      gfc_pkg::ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + gfc_pkg::CELL_W'(1);
        if (clr_cnt_q == last_cell) begin
          state_d = gfc_pkg::ST_IDLE;
        end
      end
      gfc_pkg::ST_WRITE: begin
        state_d = gfc_pkg::ST_IDLE;
      end
      default: begin
        state_d = gfc_pkg::ST_IDLE;
      end
    endcase
  end

  // Palette memory
  logic [gfc_pkg::RGB_W-1:0] pal_rdata;

  gfc_ram #(
    .Width (gfc_pkg::RGB_W),
    .Depth (PALETTE_SIZE)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (acc_load && pal_load_ok),
    .waddr_i (PalAw'(palette_index_i)),
    .wdata_i (palette_color_i),
    .re_i    (acc_pixel),
    .raddr_i (PalAw'(raster_index_i)),
    .rdata_o (pal_rdata)
  );

  // Canvas memory: sweep or pixel write-back, item-driven reads
  logic                       canvas_we, canvas_re;
  logic [CanvasAw-1:0]        canvas_waddr, canvas_raddr;
  logic [gfc_pkg::WORD_W-1:0] canvas_wdata, canvas_rdata;
  logic [gfc_pkg::RGB_W-1:0]  new_rgb;

  assign new_rgb = color_ok_q ? pal_rdata : '0;

  always_comb begin
    canvas_we    = 1'b0;
    canvas_waddr = CanvasAw'(wr_off_q);
    canvas_wdata = {canvas_rdata[gfc_pkg::WORD_W-1:gfc_pkg::RGB_W], new_rgb};
    if (state_q == gfc_pkg::ST_CLEAR) begin
      canvas_we    = 1'b1;
      canvas_waddr = CanvasAw'(clr_cnt_q);
      canvas_wdata = bg_q;
    end else if (state_q == gfc_pkg::ST_WRITE) begin
      canvas_we = 1'b1;
    end
  end

  assign canvas_re    = (acc_read && read_in_range) || (acc_pixel && draw.draw);
  assign canvas_raddr = acc_read ? CanvasAw'(read_address_i) : CanvasAw'(draw.offset);

  gfc_ram #(
    .Width (gfc_pkg::WORD_W),
    .Depth (CanvasDepth)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (canvas_we),
    .waddr_i (canvas_waddr),
    .wdata_i (canvas_wdata),
    .re_i    (canvas_re),
    .raddr_i (canvas_raddr),
    .rdata_o (canvas_rdata)
  );

  // Result beat
  assign result_valid_o  = res_valid_q;
  assign address_error_o = res_err_q;
  assign pixel_word_o    = res_err_q ? '0 : canvas_rdata;

  // Checks
  `GFC_ASSERT(a_result_follows_read, result_valid_o |-> $past(acc_read), "result without read")
  `GFC_ASSERT(a_clear_in_range, (state_q == gfc_pkg::ST_CLEAR) |-> (clr_cnt_q < n_cells), "clear past canvas")
  `GFC_ASSERT(a_draw_writes_back, (acc_pixel && draw.draw) |=> (state_q == gfc_pkg::ST_WRITE), "pixel not written")
  `GFC_ASSERT_NEVER(a_no_read_on_write, canvas_we && canvas_re, "canvas read during write")

endmodule
